[hw/rtl/jtz_pkg.sv]
// Shared types and constants for the jump test z-score block.
// Used by jtz_seqmul, jtz_dp, jtz_ctrl and the top level; no dependencies.
`default_nettype none

package jtz_pkg;

   // round((2/pi) * 2^32)
   localparam logic [31:0] TWO_OVER_PI_Q32 = 32'd2734261102;
   localparam logic [7:0]  WINDOW_RESET    = 8'd120;
   localparam logic [30:0] SUM_CAP         = 31'h7FFF_FFFF;
   localparam logic [31:0] Z_POS_SAT       = 32'h7FFF_FFFF;
   localparam logic [31:0] Z_NEG_SAT       = 32'h8000_0000;

   // shared shift-add multiplier geometry
   localparam int MUL_A_W = 96;
   localparam int MUL_B_W = 64;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   typedef enum logic [1:0] {
      MSEL_J = 2'd0,   // bipower sum times 2/pi
      MSEL_M = 2'd1,   // |J| squared
      MSEL_N = 2'd2,   // A times n
      MSEL_S = 2'd3    // quotient times 2/pi
   } mul_sel_type;

   typedef enum logic [1:0] {
      ZSRC_ZERO = 2'd0,
      ZSRC_SAT  = 2'd1,
      ZSRC_ROOT = 2'd2
   } z_src_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'd0,
      ST_WALK   = 4'd1,
      ST_DRAIN  = 4'd2,
      ST_J_GO   = 4'd3,
      ST_J_WAIT = 4'd4,
      ST_M_GO   = 4'd5,
      ST_M_WAIT = 4'd6,
      ST_N_GO   = 4'd7,
      ST_N_WAIT = 4'd8,
      ST_DIV    = 4'd9,
      ST_S_GO   = 4'd10,
      ST_S_WAIT = 4'd11,
      ST_SQRT   = 4'd12,
      ST_ROOT   = 4'd13,
      ST_FINISH = 4'd14
   } jtz_state_type;

   typedef struct packed {
      logic        accept;
      logic        walk_step;
      logic        mul_start;
      mul_sel_type mul_sel;
      logic        m_load;
      logic        a_load;
      logic        div_load;
      logic        div_step;
      logic        sqrt_load;
      logic        sqrt_step;
      logic        z_load;
      z_src_type   z_src;
      logic        out_load;
   } jtz_cmd_type;

   typedef struct packed {
      logic result_due;
      logic walk_last;
      logic pipe_empty;
      logic q_zero;
      logic mul_done;
      logic n_over;
      logic div_last;
      logic s_over;
      logic sqrt_last;
   } jtz_status_type;

endpackage

`default_nettype wire

[hw/rtl/jtz_seqmul.sv]
// Radix-2 shift-add multiplier, 96 x 64 bits.
// Depends on jtz_pkg for operand widths.
`default_nettype none

module jtz_seqmul (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [jtz_pkg::MUL_A_W-1:0] mul_a,
   input  wire logic [jtz_pkg::MUL_B_W-1:0] mul_b,
   output logic      [jtz_pkg::MUL_P_W-1:0] product,
   output logic                             done
);

   localparam int AW = jtz_pkg::MUL_A_W;
   localparam int BW = jtz_pkg::MUL_B_W;
   localparam int PW = jtz_pkg::MUL_P_W;
   localparam int CW = $clog2(BW);

   logic [AW-1:0] a_ff, a_in;
   logic [PW-1:0] acc_ff, acc_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [AW:0]   upper_sum;

   always_comb begin
      upper_sum = {1'b0, acc_ff[PW-1:BW]} + (acc_ff[0] ? {1'b0, a_ff} : {(AW+1){1'b0}});
      a_in      = a_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         a_in    = mul_a;
         acc_in  = {{AW{1'b0}}, mul_b};
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = {upper_sum, acc_ff[BW-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(BW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      acc_ff <= acc_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign product = acc_ff;
   assign done    = done_ff;

endmodule

`default_nettype wire

[hw/rtl/jtz_dp.sv]
// Datapath: return ring, window sums, z-score arithmetic (shared multiplier,
// restoring divider, bit-pair square root) and result register. Uses jtz_pkg, jtz_seqmul.
`default_nettype none

module jtz_dp #(
   parameter int MAX_WINDOW  = 254,
   parameter int RETURN_BITS = 12
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write_en,
   input  wire logic [7:0]            csr_write_data,
   input  wire logic [31:0]           req_close_price,
   input  wire jtz_pkg::jtz_cmd_type  cmd,
   output jtz_pkg::jtz_status_type    status,
   output logic signed [31:0]         rsp_z_score,
   output logic [30:0]                rsp_realized_variance,
   output logic [30:0]                rsp_bipower_variation
);

   localparam int RING_DEPTH = MAX_WINDOW + 2;
   localparam int PTR_W      = $clog2(RING_DEPTH);
   localparam int BW         = $clog2(MAX_WINDOW + 4);
   localparam int CW8        = (BW > 8) ? BW : 8;
   localparam int MAG_W      = RETURN_BITS - 1;
   localparam int SQ_W       = 2 * MAG_W;
   localparam int FQ_W       = 4 * MAG_W;
   localparam int EXT_W      = $clog2(MAX_WINDOW + 2);
   localparam int RV_W       = (SQ_W + EXT_W > 32) ? SQ_W + EXT_W : 32;
   localparam int Q_W        = (FQ_W + EXT_W > 65) ? FQ_W + EXT_W : 65;
   localparam int AW         = jtz_pkg::MUL_A_W;
   localparam int MBW        = jtz_pkg::MUL_B_W;
   localparam int PW         = jtz_pkg::MUL_P_W;
   localparam logic signed [32:0] RET_MAX = 33'((1 << (RETURN_BITS - 1)) - 1);

   // ---- history state
   logic [7:0]       window_ff, window_in;
   logic [31:0]      prev_ff, prev_in;
   logic [BW-1:0]    bars_ff, bars_in;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [BW-1:0]    n_ff, n_in;
   logic [BW-1:0]    pairs_ff, pairs_in;
   logic [BW-1:0]    j_ff, j_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;

   logic signed [RETURN_BITS-1:0] ring_mem [RING_DEPTH];
   logic signed [RETURN_BITS-1:0] rd_data_ff;
   logic                          ring_we;

   // ---- sum pipeline
   logic             p1_v_ff, p1_v_in, p1_sq_ff, p1_sq_in, p1_bp_ff, p1_bp_in;
   logic             p2_v_ff, p2_v_in, p2_sq_ff, p2_sq_in, p2_bp_ff, p2_bp_in;
   logic [MAG_W-1:0] aprev_ff, aprev_in;
   logic [SQ_W-1:0]  sq2_ff, sq2_in, bp2_ff, bp2_in;
   logic [RV_W-1:0]  rv_acc_ff, rv_acc_in, bp_acc_ff, bp_acc_in;
   logic [Q_W-1:0]   q_acc_ff, q_acc_in;

   // ---- z arithmetic
   logic [63:0] m_ff, m_in;
   logic        neg_ff, neg_in;
   logic [AW-1:0] amul_ff, amul_in;
   logic [63:0] rem_ff, rem_in, lo_ff, lo_in;
   logic [5:0]  dcnt_ff, dcnt_in;
   logic [63:0] v_ff, v_in, res_ff, res_in, bit_ff, bit_in;
   logic [4:0]  scnt_ff, scnt_in;
   logic [31:0] z_ff, z_in;

   // ---- result word
   logic [31:0] out_z_ff, out_z_in;
   logic [30:0] out_rv_ff, out_rv_in, out_bp_ff, out_bp_in;

   // ---- combinational helpers
   logic signed [32:0]            diff33, clamp33;
   logic signed [RETURN_BITS-1:0] ret_val, rd_neg;
   logic [BW-1:0]    bars_next, k_val, w_eff, w_plus1;
   logic [CW8-1:0]   win_ext;
   logic [MAG_W-1:0] a1;
   logic [FQ_W-1:0]  f2;
   logic [30:0]      rv_sat, bp_sat;
   logic [63:0]      q64, jp, jn;
   logic [AW-1:0]    mul_a;
   logic [MBW-1:0]   mul_b;
   logic [PW-1:0]    mul_prod;
   logic             mul_done;
   logic [64:0]      r65, rdiff;
   logic             dge;
   logic [63:0]      sq_t;
   logic             sge;
   logic [31:0]      root_z;

   always_comb begin
      diff33  = $signed({1'b0, req_close_price}) - $signed({1'b0, prev_ff});
      clamp33 = diff33;
      if (diff33 > RET_MAX) clamp33 = RET_MAX;
      if (diff33 < -RET_MAX) clamp33 = -RET_MAX;
      ret_val = clamp33[RETURN_BITS-1:0];

      bars_next = (bars_ff < BW'(MAX_WINDOW + 3)) ? bars_ff + 1'b1 : bars_ff;
      k_val     = bars_next - 1'b1;
      win_ext   = CW8'(window_ff);
      w_eff     = (win_ext > CW8'(MAX_WINDOW)) ? BW'(MAX_WINDOW) : BW'(window_ff);
      w_plus1   = w_eff + 1'b1;

      rd_neg = -rd_data_ff;
      a1     = rd_data_ff[RETURN_BITS-1] ? rd_neg[MAG_W-1:0] : rd_data_ff[MAG_W-1:0];
      f2     = FQ_W'(sq2_ff) * FQ_W'(sq2_ff);

      rv_sat = (|rv_acc_ff[RV_W-1:31]) ? jtz_pkg::SUM_CAP : rv_acc_ff[30:0];
      bp_sat = (|bp_acc_ff[RV_W-1:31]) ? jtz_pkg::SUM_CAP : bp_acc_ff[30:0];
      q64    = (|q_acc_ff[Q_W-1:64]) ? {64{1'b1}} : q_acc_ff[63:0];

      jp = {1'b0, rv_sat, 32'd0};
      jn = mul_prod[63:0];

      r65   = {rem_ff, lo_ff[63]};
      rdiff = r65 - {1'b0, q64};
      dge   = r65 >= {1'b0, q64};

      sq_t  = res_ff + bit_ff;
      sge   = v_ff >= sq_t;

      root_z = neg_ff ? (32'd0 - res_ff[31:0]) : res_ff[31:0];
   end

   // multiplier operands
   always_comb begin
      case (cmd.mul_sel)
         jtz_pkg::MSEL_J: begin
            mul_a = AW'(bp_sat);
            mul_b = MBW'(jtz_pkg::TWO_OVER_PI_Q32);
         end
         jtz_pkg::MSEL_M: begin
            mul_a = AW'(m_ff);
            mul_b = m_ff;
         end
         jtz_pkg::MSEL_N: begin
            mul_a = amul_ff;
            mul_b = MBW'(n_ff);
         end
         jtz_pkg::MSEL_S: begin
            mul_a = AW'(lo_ff);
            mul_b = MBW'(jtz_pkg::TWO_OVER_PI_Q32);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   jtz_seqmul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.mul_start),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .product (mul_prod),
      .done    (mul_done)
   );

   assign ring_we = cmd.accept && (bars_ff != '0);

   // next-state logic
   always_comb begin
      window_in = window_ff;
      prev_in   = prev_ff;
      bars_in   = bars_ff;
      head_in   = head_ff;
      n_in      = n_ff;
      pairs_in  = pairs_ff;
      j_in      = j_ff;
      rd_ptr_in = rd_ptr_ff;
      rv_acc_in = rv_acc_ff;
      bp_acc_in = bp_acc_ff;
      q_acc_in  = q_acc_ff;

      if (csr_write_en) begin
         window_in = csr_write_data;
         prev_in   = '0;
         bars_in   = '0;
         head_in   = '0;
         rv_acc_in = '0;
         bp_acc_in = '0;
         q_acc_in  = '0;
      end else if (cmd.accept) begin
         prev_in = req_close_price;
         if (bars_ff == '0) begin
            bars_in = BW'(1);
         end else begin
            bars_in   = bars_next;
            head_in   = (head_ff == PTR_W'(RING_DEPTH - 1)) ? '0 : head_ff + 1'b1;
            n_in      = (k_val < w_plus1) ? k_val : w_plus1;
            pairs_in  = ((k_val - 1'b1) < w_plus1) ? k_val - 1'b1 : w_plus1;
            j_in      = '0;
            rd_ptr_in = head_ff;
            rv_acc_in = '0;
            bp_acc_in = '0;
            q_acc_in  = '0;
         end
      end else begin
         if (cmd.walk_step) begin
            j_in      = j_ff + 1'b1;
            rd_ptr_in = (rd_ptr_ff == '0) ? PTR_W'(RING_DEPTH - 1) : rd_ptr_ff - 1'b1;
         end
         if (p2_v_ff && p2_sq_ff) begin
            rv_acc_in = rv_acc_ff + RV_W'(sq2_ff);
            q_acc_in  = q_acc_ff + Q_W'(f2);
         end
         if (p2_v_ff && p2_bp_ff) begin
            bp_acc_in = bp_acc_ff + RV_W'(bp2_ff);
         end
      end

      // pipeline: read -> square/product -> accumulate
      p1_v_in  = cmd.walk_step;
      p1_sq_in = j_ff < n_ff;
      p1_bp_in = j_ff != '0;
      p2_v_in  = p1_v_ff;
      p2_sq_in = p1_sq_ff;
      p2_bp_in = p1_bp_ff;
      aprev_in = p1_v_ff ? a1 : aprev_ff;
      sq2_in   = SQ_W'(a1) * SQ_W'(a1);
      bp2_in   = SQ_W'(a1) * SQ_W'(aprev_ff);

      // z arithmetic
      m_in    = m_ff;
      neg_in  = neg_ff;
      amul_in = amul_ff;
      rem_in  = rem_ff;
      lo_in   = lo_ff;
      dcnt_in = dcnt_ff;
      v_in    = v_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      scnt_in = scnt_ff;
      z_in    = z_ff;

      if (cmd.m_load) begin
         neg_in = jn > jp;
         m_in   = (jn > jp) ? jn - jp : jp - jn;
      end
      if (cmd.a_load) begin
         amul_in = mul_prod[AW+31:32];
      end
      if (cmd.div_load) begin
         rem_in  = mul_prod[127:64];
         lo_in   = mul_prod[63:0];
         dcnt_in = '0;
      end else if (cmd.div_step) begin
         rem_in  = dge ? rdiff[63:0] : r65[63:0];
         lo_in   = {lo_ff[62:0], dge};
         dcnt_in = dcnt_ff + 1'b1;
      end
      if (cmd.sqrt_load) begin
         v_in    = mul_prod[95:32];
         res_in  = '0;
         bit_in  = 64'd1 << 62;
         scnt_in = '0;
      end else if (cmd.sqrt_step) begin
         v_in    = sge ? v_ff - sq_t : v_ff;
         res_in  = sge ? (res_ff >> 1) + bit_ff : res_ff >> 1;
         bit_in  = bit_ff >> 2;
         scnt_in = scnt_ff + 1'b1;
      end
      if (cmd.z_load) begin
         case (cmd.z_src)
            jtz_pkg::ZSRC_ZERO: z_in = '0;
            jtz_pkg::ZSRC_SAT:  z_in = neg_ff ? jtz_pkg::Z_NEG_SAT : jtz_pkg::Z_POS_SAT;
            jtz_pkg::ZSRC_ROOT: z_in = root_z;
            default:            z_in = '0;
         endcase
      end

      out_z_in  = cmd.out_load ? z_ff   : out_z_ff;
      out_rv_in = cmd.out_load ? rv_sat : out_rv_ff;
      out_bp_in = cmd.out_load ? bp_sat : out_bp_ff;
   end

   // return ring
   always_ff @(posedge clock) begin
      if (ring_we) ring_mem[head_ff] <= ret_val;
      rd_data_ff <= ring_mem[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= jtz_pkg::WINDOW_RESET;
         prev_ff   <= '0;
         bars_ff   <= '0;
         head_ff   <= '0;
         rv_acc_ff <= '0;
         bp_acc_ff <= '0;
         q_acc_ff  <= '0;
         p1_v_ff   <= 1'b0;
         p2_v_ff   <= 1'b0;
         j_ff      <= '0;
         dcnt_ff   <= '0;
         scnt_ff   <= '0;
      end else begin
         window_ff <= window_in;
         prev_ff   <= prev_in;
         bars_ff   <= bars_in;
         head_ff   <= head_in;
         rv_acc_ff <= rv_acc_in;
         bp_acc_ff <= bp_acc_in;
         q_acc_ff  <= q_acc_in;
         p1_v_ff   <= p1_v_in;
         p2_v_ff   <= p2_v_in;
         j_ff      <= j_in;
         dcnt_ff   <= dcnt_in;
         scnt_ff   <= scnt_in;
      end
      n_ff      <= n_in;
      pairs_ff  <= pairs_in;
      rd_ptr_ff <= rd_ptr_in;
      p1_sq_ff  <= p1_sq_in;
      p1_bp_ff  <= p1_bp_in;
      p2_sq_ff  <= p2_sq_in;
      p2_bp_ff  <= p2_bp_in;
      aprev_ff  <= aprev_in;
      sq2_ff    <= sq2_in;
      bp2_ff    <= bp2_in;
      m_ff      <= m_in;
      neg_ff    <= neg_in;
      amul_ff   <= amul_in;
      rem_ff    <= rem_in;
      lo_ff     <= lo_in;
      v_ff      <= v_in;
      res_ff    <= res_in;
      bit_ff    <= bit_in;
      z_ff      <= z_in;
      out_z_ff  <= out_z_in;
      out_rv_ff <= out_rv_in;
      out_bp_ff <= out_bp_in;
   end

   always_comb begin
      status.result_due = bars_ff >= BW'(2);
      status.walk_last  = j_ff == pairs_ff;
      status.pipe_empty = !p1_v_ff && !p2_v_ff;
      status.q_zero     = q64 == '0;
      status.mul_done   = mul_done;
      status.n_over     = mul_prod[127:64] >= q64;
      status.div_last   = dcnt_ff == 6'd63;
      status.s_over     = |mul_prod[PW-1:94];
      status.sqrt_last  = scnt_ff == 5'd31;
   end

   assign rsp_z_score           = out_z_ff;
   assign rsp_realized_variance = out_rv_ff;
   assign rsp_bipower_variation = out_bp_ff;

endmodule

`default_nettype wire

[hw/rtl/jtz_ctrl.sv]
// Sequencer for the jump test block: walks the window, then steps the
// multiplier, divider and root; owns the handshakes. Uses jtz_pkg.
`default_nettype none

module jtz_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   input  wire jtz_pkg::jtz_status_type status,
   output jtz_pkg::jtz_cmd_type         cmd
);

   jtz_pkg::jtz_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;
   logic out_free;

   assign req_stall = state_ff != jtz_pkg::ST_IDLE;
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         jtz_pkg::ST_IDLE:   if (accept && status.result_due) state_in = jtz_pkg::ST_WALK;
         jtz_pkg::ST_WALK:   if (status.walk_last) state_in = jtz_pkg::ST_DRAIN;
         jtz_pkg::ST_DRAIN: begin
            if (status.pipe_empty)
               state_in = status.q_zero ? jtz_pkg::ST_FINISH : jtz_pkg::ST_J_GO;
         end
         jtz_pkg::ST_J_GO:   state_in = jtz_pkg::ST_J_WAIT;
         jtz_pkg::ST_J_WAIT: if (status.mul_done) state_in = jtz_pkg::ST_M_GO;
         jtz_pkg::ST_M_GO:   state_in = jtz_pkg::ST_M_WAIT;
         jtz_pkg::ST_M_WAIT: if (status.mul_done) state_in = jtz_pkg::ST_N_GO;
         jtz_pkg::ST_N_GO:   state_in = jtz_pkg::ST_N_WAIT;
         jtz_pkg::ST_N_WAIT: begin
            if (status.mul_done)
               state_in = status.n_over ? jtz_pkg::ST_FINISH : jtz_pkg::ST_DIV;
         end
         jtz_pkg::ST_DIV:    if (status.div_last) state_in = jtz_pkg::ST_S_GO;
         jtz_pkg::ST_S_GO:   state_in = jtz_pkg::ST_S_WAIT;
         jtz_pkg::ST_S_WAIT: begin
            if (status.mul_done)
               state_in = status.s_over ? jtz_pkg::ST_FINISH : jtz_pkg::ST_SQRT;
         end
         jtz_pkg::ST_SQRT:   if (status.sqrt_last) state_in = jtz_pkg::ST_ROOT;
         jtz_pkg::ST_ROOT:   state_in = jtz_pkg::ST_FINISH;
         jtz_pkg::ST_FINISH: if (out_free) state_in = jtz_pkg::ST_IDLE;
         default:            state_in = jtz_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd           = '0;
      cmd.mul_sel   = jtz_pkg::MSEL_J;
      cmd.z_src     = jtz_pkg::ZSRC_ZERO;
      cmd.accept    = accept;
      case (state_ff)
         jtz_pkg::ST_WALK:  cmd.walk_step = 1'b1;
         jtz_pkg::ST_DRAIN: begin
            if (status.pipe_empty && status.q_zero) begin
               cmd.z_load = 1'b1;
               cmd.z_src  = jtz_pkg::ZSRC_ZERO;
            end
         end
         jtz_pkg::ST_J_GO: begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = jtz_pkg::MSEL_J;
         end
         jtz_pkg::ST_J_WAIT: cmd.m_load = status.mul_done;
         jtz_pkg::ST_M_GO: begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = jtz_pkg::MSEL_M;
         end
         jtz_pkg::ST_M_WAIT: cmd.a_load = status.mul_done;
         jtz_pkg::ST_N_GO: begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = jtz_pkg::MSEL_N;
         end
         jtz_pkg::ST_N_WAIT: begin
            if (status.mul_done) begin
               cmd.z_load   = status.n_over;
               cmd.z_src    = jtz_pkg::ZSRC_SAT;
               cmd.div_load = !status.n_over;
            end
         end
         jtz_pkg::ST_DIV: cmd.div_step = 1'b1;
         jtz_pkg::ST_S_GO: begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = jtz_pkg::MSEL_S;
         end
         jtz_pkg::ST_S_WAIT: begin
            if (status.mul_done) begin
               cmd.z_load    = status.s_over;
               cmd.z_src     = jtz_pkg::ZSRC_SAT;
               cmd.sqrt_load = !status.s_over;
            end
         end
         jtz_pkg::ST_SQRT: cmd.sqrt_step = 1'b1;
         jtz_pkg::ST_ROOT: begin
            cmd.z_load = 1'b1;
            cmd.z_src  = jtz_pkg::ZSRC_ROOT;
         end
         jtz_pkg::ST_FINISH: cmd.out_load = out_free;
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.out_load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= jtz_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

[hw/rtl/jump_test_z_score.sv]
// Jump test z-score: one closing price per word, one result word per price from the third on.
// Per price, from accept to rsp_valid (pairs = bipower terms, up to W+1):
//   pairs+1 ring reads, pipe drain, four products on the shared multiplier,
//   64-step divide, 32-step root, sign, load. Zero Q or saturation ends sooner.
// Next price waits for the last result load, which an output stall can delay. After reset
//   or a window write the first two prices start no run. Reset: window 120, history empty.
`default_nettype none

module jump_test_z_score #(
   parameter int MAX_WINDOW  = 254,  // deepest window; ring holds MAX_WINDOW+2 returns
   parameter int RETURN_BITS = 12    // signed width of a stored (clamped) return
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // configuration: window length in bars
   input  wire logic               csr_write_en,
   input  wire logic [7:0]         csr_write_data,
   // price words in
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [31:0]        req_close_price,
   // result words out
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_z_score,
   output logic [30:0]             rsp_realized_variance,
   output logic [30:0]             rsp_bipower_variation
);

   // The controller only sequences; all arithmetic and history sit in the datapath.
   // A finished word waits in the datapath's result register, so a new price is
   // taken while the previous result is still stalled downstream.
   jtz_pkg::jtz_cmd_type    cmd;
   jtz_pkg::jtz_status_type status;

   jtz_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: ring of clamped returns, walked newest first through a three-stage
   // read/square/accumulate pipe; then J = (RV - BP*(2/pi))*2^32, |J|^2 >> 32, times n,
   // divided by Q, times 2/pi, integer root, signed and saturated to Q16.16.
   jtz_dp #(
      .MAX_WINDOW  (MAX_WINDOW),
      .RETURN_BITS (RETURN_BITS)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .csr_write_en          (csr_write_en),
      .csr_write_data        (csr_write_data),
      .req_close_price       (req_close_price),
      .cmd                   (cmd),
      .status                (status),
      .rsp_z_score           (rsp_z_score),
      .rsp_realized_variance (rsp_realized_variance),
      .rsp_bipower_variation (rsp_bipower_variation)
   );

endmodule

`default_nettype wire

[tb/tb_jump_test_z_score.sv]
// Self-checking testbench for jump_test_z_score: drives closing prices, predicts each
// z-score / RV / BP word and compares the block's result words. Depends on jtz_pkg.
// No files, no arguments; random values come from the simulator's seed.
`default_nettype none

module tb_jump_test_z_score;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_WIN    = 254;
   localparam int RING_SLOTS = MAX_WIN + 2;
   localparam int RET_LIMIT  = 2047;
   localparam int BARS_CAP   = MAX_WIN + 3;

   typedef struct {
      logic signed [31:0] z;
      logic [30:0]        rv;
      logic [30:0]        bp;
   } jump_word_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_write_en = 1'b0;
   logic [7:0]         csr_write_data = 8'd0;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [31:0]        req_close_price = 32'd0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_z_score;
   logic [30:0]        rsp_realized_variance;
   logic [30:0]        rsp_bipower_variation;

   jump_test_z_score dut (
      .clock                 (clock),
      .reset                 (reset),
      .csr_write_en          (csr_write_en),
      .csr_write_data        (csr_write_data),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_close_price       (req_close_price),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_z_score           (rsp_z_score),
      .rsp_realized_variance (rsp_realized_variance),
      .rsp_bipower_variation (rsp_bipower_variation)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor state: our own copy of the return history and window
   // ---------------------------------------------------------------------
   logic signed [11:0] ret_hist [RING_SLOTS];
   logic [31:0]        last_close;
   int                 bars_held;
   int                 hist_head;
   logic [7:0]         window_bars;

   jump_word_type      pending_words [$];
   int                 error_count = 0;
   int                 prices_sent = 0;
   int                 words_checked = 0;
   int                 windows_tried = 0;
   int                 sat_words = 0;
   int                 zero_q_words = 0;

   // idling percentages, changed per phase
   int                 tx_idle_pct = 0;
   int                 rx_idle_pct = 0;
   logic [31:0]        walk_price = 32'd0;

   function automatic void clear_history();
      last_close = '0;
      bars_held  = 0;
      hist_head  = 0;
   endfunction

   // z = (RV - (2/pi)BP) / sqrt((pi/2)Q/n) in Q16.16, fixed-point sequence:
   // |J|^2 >> 32, times n, over Q, times 2/pi >> 32, integer root
   function automatic logic [31:0] jump_z(logic [30:0] rv, logic [30:0] bp,
                                          logic [63:0] q, int n);
      logic [63:0]  jp, jn, mag_j, s, root, trial;
      logic         neg;
      logic [127:0] sq, s_full;
      logic [103:0] scaled, quo;
      if (q == 0)
         return 32'd0;
      jp     = {1'b0, rv, 32'd0};
      jn     = 64'(bp) * 64'(jtz_pkg::TWO_OVER_PI_Q32);
      neg    = jn > jp;
      mag_j  = neg ? jn - jp : jp - jn;
      sq     = 128'(mag_j) * 128'(mag_j);
      scaled = 104'(sq[127:32]) * 104'(n);
      quo    = scaled / 104'(q);
      if (quo[103:64] != 0)
         return neg ? jtz_pkg::Z_NEG_SAT : jtz_pkg::Z_POS_SAT;
      s_full = 128'(quo[63:0]) * 128'(jtz_pkg::TWO_OVER_PI_Q32);
      s      = s_full[95:32];
      if (s >= (64'd1 << 62))
         return neg ? jtz_pkg::Z_NEG_SAT : jtz_pkg::Z_POS_SAT;
      root = 0;
      for (int i = 31; i >= 0; i--) begin
         trial = root | (64'd1 << i);
         if (trial * trial <= s)
            root = trial;
      end
      return neg ? 32'(-root) : root[31:0];
   endfunction

   // advance the history by one accepted price; queue a word when one is due
   function automatic void predict_bar(logic [31:0] price);
      longint        diff;
      int            w, k, n, pairs, pos0, pos1;
      longint        a0, a1;
      logic [63:0]   rv, q, bp;
      jump_word_type exp_word;
      if (bars_held == 0) begin
         last_close = price;
         bars_held  = 1;
         return;
      end
      diff = longint'(price) - longint'(last_close);
      if (diff > RET_LIMIT)  diff = RET_LIMIT;
      if (diff < -RET_LIMIT) diff = -RET_LIMIT;
      last_close          = price;
      ret_hist[hist_head] = 12'(diff);
      hist_head           = (hist_head + 1) % RING_SLOTS;
      if (bars_held < BARS_CAP)
         bars_held++;
      if (bars_held < 3)
         return;

      w     = (window_bars > MAX_WIN) ? MAX_WIN : int'(window_bars);
      k     = bars_held - 1;
      n     = (k < w + 1) ? k : w + 1;
      pairs = (k - 1 < w + 1) ? k - 1 : w + 1;
      rv = 0; q = 0; bp = 0;
      for (int j = 0; j < n; j++) begin
         pos0 = (hist_head + RING_SLOTS - 1 - j) % RING_SLOTS;
         a0   = ret_hist[pos0] < 0 ? -longint'(ret_hist[pos0]) : longint'(ret_hist[pos0]);
         rv  += 64'(a0 * a0);
         q   += 64'(a0 * a0 * a0 * a0);
      end
      for (int j = 0; j < pairs; j++) begin
         pos0 = (hist_head + RING_SLOTS - 1 - j) % RING_SLOTS;
         pos1 = (hist_head + RING_SLOTS - 2 - j) % RING_SLOTS;
         a0   = ret_hist[pos0] < 0 ? -longint'(ret_hist[pos0]) : longint'(ret_hist[pos0]);
         a1   = ret_hist[pos1] < 0 ? -longint'(ret_hist[pos1]) : longint'(ret_hist[pos1]);
         bp  += 64'(a0 * a1);
      end
      if (rv > 64'(jtz_pkg::SUM_CAP)) rv = 64'(jtz_pkg::SUM_CAP);
      if (bp > 64'(jtz_pkg::SUM_CAP)) bp = 64'(jtz_pkg::SUM_CAP);
      exp_word.rv = rv[30:0];
      exp_word.bp = bp[30:0];
      exp_word.z  = jump_z(rv[30:0], bp[30:0], q, n);
      if (q == 0) zero_q_words++;
      if (exp_word.z == jtz_pkg::Z_POS_SAT || exp_word.z == jtz_pkg::Z_NEG_SAT) sat_words++;
      pending_words.push_back(exp_word);
   endfunction

   // ---------------------------------------------------------------------
   // Sender side
   // ---------------------------------------------------------------------
   // valid is left high after acceptance so back-to-back words need no gap;
   // hold_off lowers it whenever no word follows straight away
   task automatic send_price(logic [31:0] price);
      @(negedge clock);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_close_price <= price;
      do @(posedge clock); while (req_stall);
      predict_bar(price);
      prices_sent++;
   endtask

   task automatic hold_off();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // drain, then let a price that gives no word finish before touching the window
   task automatic wait_idle();
      hold_off();
      while (pending_words.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_window(logic [7:0] bars);
      wait_idle();
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= bars;
      @(negedge clock);
      csr_write_en   <= 1'b0;
      window_bars = bars;
      clear_history();
      windows_tried++;
   endtask

   // mostly a random walk; some flat bars, clamped jumps and wild prices
   function automatic logic [31:0] next_price(logic [31:0] prev);
      int pick;
      pick = $urandom_range(99);
      if (pick < 55)      return prev + 32'($urandom_range(80)) - 32'd40;
      else if (pick < 72) return prev;
      else if (pick < 87) return prev + 32'($urandom_range(6000)) - 32'd3000;
      else if (pick < 95) return $urandom;
      else                return prev ^ (32'd1 << $urandom_range(31));
   endfunction

   task automatic send_walk(int count);
      for (int i = 0; i < count; i++) begin
         walk_price = next_price(walk_price);
         send_price(walk_price);
      end
   endtask

   // ---------------------------------------------------------------------
   // Result checker
   // ---------------------------------------------------------------------
   always @(negedge clock)
      rsp_stall <= ($urandom_range(99) < rx_idle_pct);

   always @(posedge clock) begin
      jump_word_type exp_word;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_words.size() == 0) begin
            $error("result word with nothing expected: z=%0d rv=%0d bp=%0d",
                   rsp_z_score, rsp_realized_variance, rsp_bipower_variation);
            error_count++;
         end else begin
            exp_word = pending_words.pop_front();
            words_checked++;
            if (rsp_z_score !== exp_word.z) begin
               $error("z_score: expected %0d, got %0d", exp_word.z, rsp_z_score);
               error_count++;
            end
            if (rsp_realized_variance !== exp_word.rv) begin
               $error("realized_variance: expected %0d, got %0d",
                      exp_word.rv, rsp_realized_variance);
               error_count++;
            end
            if (rsp_bipower_variation !== exp_word.bp) begin
               $error("bipower_variation: expected %0d, got %0d",
                      exp_word.bp, rsp_bipower_variation);
               error_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   // reset window (120): the first two prices give no word, flat bars give Q = 0,
   // full-scale swings clamp both ways, all price bits toggle
   task automatic test_edge_prices();
      send_price(32'd100);
      send_price(32'd100);
      send_price(32'd100);
      send_price(32'hFFFF_FFFF);
      send_price(32'd0);
      send_price(32'h5555_5555);
      send_price(32'hAAAA_AAAA);
      send_price(32'hAAAA_AAAA + 32'd2047);
      send_price(32'hAAAA_AAAA);
      send_price(32'hAAAA_AAAB);
      send_price(32'hAAAA_AAAB);
      walk_price = 32'hAAAA_AAAB;
      hold_off();
   endtask

   // window extremes, including the above-maximum setting and the clear on write
   task automatic test_window_extremes();
      logic [7:0] bars_list [6] = '{8'd0, 8'd1, 8'd255, 8'd254, 8'd2, 8'd120};
      foreach (bars_list[i]) begin
         write_window(bars_list[i]);
         walk_price = $urandom;
         send_walk(bars_list[i] == 8'd0 ? 4 : 2);
      end
      hold_off();
   endtask

   // random walks under one idling mix, window rewritten now and then
   task automatic test_random_walk(int tx_pct, int rx_pct, int count);
      int left, chunk;
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      left = count;
      while (left > 0) begin
         case ($urandom_range(4))
            0:       write_window(8'd0);
            1:       write_window(8'($urandom_range(255, 250)));
            default: write_window(8'($urandom_range(255)));
         endcase
         chunk = $urandom_range(70, 20);
         if (chunk > left) chunk = left;
         send_walk(chunk);
         left -= chunk;
      end
      hold_off();
   endtask

   // full window with a history long enough to wrap the ring
   task automatic test_ring_wrap();
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      write_window(8'd254);
      send_walk(280);
      hold_off();
   endtask

   initial begin
      window_bars = jtz_pkg::WINDOW_RESET;
      clear_history();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_edge_prices();
      test_window_extremes();
      test_random_walk(28, 55, 130);
      test_random_walk(55, 28, 130);
      test_random_walk(0, 0, 60);
      test_ring_wrap();

      hold_off();
      while (pending_words.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);

      $display("Ran %0d prices over %0d window settings; %0d result words checked,",
               prices_sent, windows_tried, words_checked);
      $display("%0d of them with zero fourth-power sum and %0d with saturated z.",
               zero_q_words, sat_words);
      if (error_count == 0 && pending_words.size() == 0)
         $display("PASS jump_test_z_score");
      else
         $display("FAIL jump_test_z_score");
      $finish;
   end

   // watchdog: well beyond the slowest legal run of about 630 prices
   initial begin
      #20_000_000;
      $display("FAIL jump_test_z_score");
      $finish;
   end

endmodule

`default_nettype wire

[sim.f]
hw/rtl/jtz_pkg.sv
hw/rtl/jtz_seqmul.sv
hw/rtl/jtz_dp.sv
hw/rtl/jtz_ctrl.sv
hw/rtl/jump_test_z_score.sv
tb/tb_jump_test_z_score.sv
